// File: src/lfsm_pkg.sv
// ----------------------------------------------------------------------------
// lfsm_pkg
// Shared types, register codes and the quarter-wave sine entry function for
// the flanger with a sine lfo and recursive mix.
// ----------------------------------------------------------------------------
package lfsm_pkg;

  localparam int PHASE_W = 32;
  localparam int DELAY_W = 5;
  localparam int SINE_W  = 16;
  localparam int MAG_W   = SINE_W - 1;
  localparam int PROD_W  = SINE_W + DELAY_W;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 5'd20;

  // register select bit of the byte address
  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_MAX_DELAY  = 1'b1;

  localparam longint SIN_A = 64'sd1686629713;
  localparam longint SIN_B = 64'sd693598564;
  localparam longint SIN_C = 64'sd80710675;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_SELF,
    SEL_FIRST,
    SEL_HIST
  } mix_sel_t;

  // magnitude of the sine at a quarter-turn position, evaluated at elaboration
  function automatic logic [MAG_W-1:0] quarter_sine(input int pos, input int stb);
    longint x;
    longint x2;
    longint t;
    x  = longint'(pos) <<< (32 - stb);
    x2 = (x * x) >>> 30;
    t  = (SIN_C * x2) >>> 30;
    t  = SIN_B - t;
    t  = (t * x2) >>> 30;
    t  = SIN_A - t;
    t  = (t * x) >>> 30;
    t  = t >>> 15;
    if (t > 64'sd32767) begin
      t = 64'sd32767;
    end
    return t[MAG_W-1:0];
  endfunction

endpackage

// File: src/lfo_flanger_recursive_mix.sv
// ----------------------------------------------------------------------------
// lfo_flanger_recursive_mix
// Flanger: a sine lfo sets a delay per sample, the output is the floor of
// half the sum of the input and an earlier output held in a history ring.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in_       input      in_valid / in_stall   in_sample_in, in_first
//  out_      output     out_valid / out_stall out_sample_out
//  config    input      psel/penable/pwrite   paddr, pwdata, prdata, pready
//
//  one item per cycle sustained while the output is not stalled; a result
//  is shown after passing the lfo stage, delay stage, history read and mix
//  the history ring is one memory, read in the cycle before the mix; a
//  delay of one is served from the item in the mix stage
//  rst_n clears control state only; the ring needs no clearing pass
//  a stall on the output holds the pipeline back stage by stage
// ----------------------------------------------------------------------------
module lfo_flanger_recursive_mix #(
  parameter int HISTORY_DEPTH   = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_in,
  input  logic                              in_first,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_sample_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lfsm_pkg::ADDR_W-1:0]       paddr,
  input  logic [lfsm_pkg::DATA_W-1:0]       pwdata,
  output logic [lfsm_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  import lfsm_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int PW    = $clog2(HISTORY_DEPTH);
  localparam int CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int CMPW  = (CW > DELAY_W) ? CW : DELAY_W;
  localparam int AW    = (PW + 1 > CMPW) ? PW + 1 : CMPW;
  localparam int STB   = SINE_TABLE_BITS;
  localparam int QLEN  = 1 << (STB - 2);
  localparam int POSW  = STB - 1;

  localparam logic [CW-1:0]   CNT_MAX  = CW'(HISTORY_DEPTH);
  localparam logic [PW-1:0]   WP_LAST  = PW'(HISTORY_DEPTH - 1);
  localparam logic [CMPW-1:0] DEPTH_C  = CMPW'(HISTORY_DEPTH);
  localparam logic [AW-1:0]   DEPTH_A  = AW'(HISTORY_DEPTH);
  localparam logic [POSW-1:0] QLEN_P   = POSW'(QLEN);

  // configuration
  logic [PHASE_W-1:0] phase_step_r;
  logic [DELAY_W-1:0] max_delay_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      max_delay_r  <= MAX_DELAY_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_PHASE_STEP: phase_step_r <= pwdata;
        REG_MAX_DELAY:  max_delay_r  <= pwdata[DELAY_W-1:0];
        default:        phase_step_r <= phase_step_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_PHASE_STEP: prdata = phase_step_r;
        REG_MAX_DELAY:  prdata = DATA_W'(max_delay_r);
        default:        prdata = '0;
      endcase
    end
  end

  // pipeline control
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic accept, adv1, adv2, adv3;

  assign adv3     = v3_r & (~out_valid_r | ~out_stall);
  assign adv2     = v2_r & (~v3_r | adv3);
  assign adv1     = v1_r & (~v2_r | adv2);
  assign in_stall = v1_r & ~adv1;
  assign accept   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept | (v1_r & ~adv1);
      v2_r        <= adv1 | (v2_r & ~adv2);
      v3_r        <= adv2 | (v3_r & ~adv3);
      out_valid_r <= adv3 | (out_valid_r & out_stall);
    end
  end

  // accept stage: lfo phase, count and write pointer
  logic [PHASE_W-1:0] phase_r, phase_cur, phase_nxt;
  logic [CW-1:0]      cnt_r, cnt_cur, cnt_nxt;
  logic [PW-1:0]      wp_r, wp_cur, wp_nxt;
  logic [STB-1:0]     idx;
  logic [STB-3:0]     u;
  logic [POSW-1:0]    pos_nxt;

  always_comb begin
    phase_cur = in_first ? '0 : phase_r;
    cnt_cur   = in_first ? '0 : cnt_r;
    wp_cur    = in_first ? '0 : wp_r;
    phase_nxt = phase_cur + phase_step_r;
    cnt_nxt   = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + CW'(1);
    wp_nxt    = (wp_cur == WP_LAST) ? '0 : wp_cur + PW'(1);
    idx       = phase_cur[PHASE_W-1 -: STB];
    u         = idx[STB-3:0];
    pos_nxt   = idx[STB-2] ? (QLEN_P - POSW'(u)) : POSW'(u);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      cnt_r   <= '0;
      wp_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      wp_r    <= wp_nxt;
    end
  end

  logic signed [SB-1:0] x1_r;
  logic [CW-1:0]        cnt1_r;
  logic [PW-1:0]        wp1_r;
  logic                 neg1_r;
  logic [POSW-1:0]      pos1_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      x1_r   <= in_sample_in;
      cnt1_r <= cnt_cur;
      wp1_r  <= wp_cur;
      neg1_r <= idx[STB-1];
      pos1_r <= pos_nxt;
    end
  end

  // sine stage: quarter-wave table, sign, delay scale
  logic [MAG_W-1:0]  sine_rom [QLEN + 1];
  logic [SINE_W-1:0] sine_s;
  logic [SINE_W-1:0] sine_off;
  logic [PROD_W-1:0] prod;
  logic [DELAY_W-1:0] d_nxt;

  for (genvar g = 0; g <= QLEN; g++) begin : g_rom
    assign sine_rom[g] = quarter_sine(g, STB);
  end

  always_comb begin
    sine_s   = neg1_r ? (SINE_W'(0) - SINE_W'(sine_rom[pos1_r])) : SINE_W'(sine_rom[pos1_r]);
    sine_off = {~sine_s[SINE_W-1], sine_s[SINE_W-2:0]};
    prod     = PROD_W'(sine_off) * PROD_W'(max_delay_r);
    d_nxt    = prod[PROD_W-1 -: DELAY_W];
  end

  logic signed [SB-1:0] x2_r;
  logic [CW-1:0]        cnt2_r;
  logic [PW-1:0]        wp2_r;
  logic [DELAY_W-1:0]   d2_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      x2_r   <= x1_r;
      cnt2_r <= cnt1_r;
      wp2_r  <= wp1_r;
      d2_r   <= d_nxt;
    end
  end

  // read stage: clamp delay, pick the source, address the ring
  logic [CMPW-1:0] d_cl, cnt_ext;
  logic [AW-1:0]   wp_a, d_a, rd_full;
  logic [PW-1:0]   rd2;
  mix_sel_t        sel_nxt;
  logic            fwd_nxt;

  logic signed [SB-1:0] x3_r;
  logic                 cnt0_3_r;
  logic [PW-1:0]        wp3_r;
  mix_sel_t             sel3_r;
  logic                 fwd3_r;
  logic signed [SB-1:0] fwd_y_r;
  logic signed [SB-1:0] y3;

  always_comb begin
    d_cl    = (CMPW'(d2_r) > DEPTH_C) ? DEPTH_C : CMPW'(d2_r);
    cnt_ext = CMPW'(cnt2_r);
    wp_a    = AW'(wp2_r);
    d_a     = AW'(d_cl);
    rd_full = (wp_a >= d_a) ? (wp_a - d_a) : (wp_a + DEPTH_A - d_a);
    rd2     = rd_full[PW-1:0];
    priority if (d_cl == '0) begin
      sel_nxt = SEL_ZERO;
    end else if (d_cl > cnt_ext) begin
      sel_nxt = (cnt2_r == '0) ? SEL_SELF : SEL_FIRST;
    end else begin
      sel_nxt = SEL_HIST;
    end
    // previous item is written at the same edge as this read
    fwd_nxt = v3_r & (wp3_r == rd2);
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      x3_r     <= x2_r;
      cnt0_3_r <= (cnt2_r == '0);
      wp3_r    <= wp2_r;
      sel3_r   <= sel_nxt;
      fwd3_r   <= fwd_nxt;
      fwd_y_r  <= y3;
    end
  end

  logic [SB-1:0] hist_rdata;

  lfsm_ram #(
    .WIDTH (SB),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (adv3),
    .waddr (wp3_r),
    .wdata (y3),
    .re    (adv2),
    .raddr (rd2),
    .rdata (hist_rdata)
  );

  // mix stage
  logic signed [SB-1:0] first_out_r;
  logic signed [SB-1:0] delayed;
  logic signed [SB:0]   sum;

  always_comb begin
    unique case (sel3_r)
      SEL_ZERO:  delayed = '0;
      SEL_SELF:  delayed = x3_r;
      SEL_FIRST: delayed = first_out_r;
      SEL_HIST:  delayed = fwd3_r ? fwd_y_r : $signed(hist_rdata);
      default:   delayed = '0;
    endcase
    sum = {x3_r[SB-1], x3_r} + {delayed[SB-1], delayed};
    y3  = sum[SB:1];
  end

  logic signed [SB-1:0] sample_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_out_r <= '0;
    end else if (adv3 && cnt0_3_r) begin
      first_out_r <= y3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      sample_out_r <= y3;
    end
  end

  assign out_sample_out = sample_out_r;

  // checks
  a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_first |=> (wp_r == PW'(1)) && (cnt_r == CW'(1)))
    else $error("first item did not restart pointer and count");

  a_fwd_delay_one: assert property (@(posedge clk) disable iff (!rst_n)
    adv2 && fwd_nxt && (sel_nxt == SEL_HIST) |-> (d_cl == CMPW'(1)))
    else $error("forwarding taken for a delay other than one");

  a_out_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v3_r))
    else $error("result shown without an item in the mix stage");

endmodule

// File: src/lfsm_ram.sv
// ----------------------------------------------------------------------------
// lfsm_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module lfsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
